FILE: rtl/core/cqe_pkg.sv
// shared types, codes and index helpers for the circular queue engine
`default_nettype none
package cqe_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QS_W = 7;

    typedef enum logic [1:0] {
        KIND_ENQ  = 2'd0,
        KIND_DEQ  = 2'd1,
        KIND_DISP = 2'd2,
        KIND_PEEK = 2'd3
    } cqe_kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } cqe_status_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } cqe_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic               last;
    } cqe_out_t;

    // controller to datapath
    typedef struct packed {
        logic        load;
        logic        write_first;
        logic        write_next;
        logic        read_head;
        logic        read_next;
        logic        pop;
        logic        emit;
        cqe_status_t emit_status;
        logic        emit_last;
    } cqe_cmd_t;

    // datapath to controller
    typedef struct packed {
        cqe_kind_t kind;
        logic      empty;
        logic      full;
        logic      walk_last;
    } cqe_stat_t;

    // next slot, wrapping at the clamped capacity
    function automatic logic [IDX_W-1:0] cqe_advance(input logic [IDX_W-1:0] idx,
                                                     input logic [QS_W-1:0] qs);
        logic [QS_W+IDX_W:0] n;
        logic [QS_W+IDX_W:0] cap;
        n = (QS_W+IDX_W+1)'(idx) + 1'b1;
        if (qs == '0)
            cap = (QS_W+IDX_W+1)'(1);
        else if ((QS_W+IDX_W+1)'(qs) > (QS_W+IDX_W+1)'(DEPTH))
            cap = (QS_W+IDX_W+1)'(DEPTH);
        else
            cap = (QS_W+IDX_W+1)'(qs);
        if (n >= cap || n >= (QS_W+IDX_W+1)'(DEPTH))
            return '0;
        return n[IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cqe_ctrl.sv
// controller state machine of the circular queue engine
`default_nettype none
module cqe_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire cqe_pkg::cqe_stat_t stat,
    output cqe_pkg::cqe_cmd_t      cmd,
    output logic                   busy
);
    import cqe_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    always_comb
    begin
        cmd = '0;
        cmd.emit_status = ST_OK;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                if (stat.kind == KIND_ENQ)
                begin
                    if (stat.empty)
                        cmd.write_first = 1'b1;
                    else if (stat.full)
                    begin
                        cmd.emit = 1'b1;
                        cmd.emit_status = ST_FULL;
                        cmd.emit_last = 1'b1;
                    end
                    else
                        cmd.write_next = 1'b1;
                end
                else if (stat.empty)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_status = ST_EMPTY;
                    cmd.emit_last = 1'b1;
                end
                else
                begin
                    cmd.read_head = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                cmd.emit_status = ST_OK;
                cmd.emit_last = stat.walk_last || (stat.kind != KIND_DISP);
                cmd.pop = (stat.kind == KIND_DEQ);
                if (cmd.emit_last)
                    state_next = S_IDLE;
                else
                    cmd.read_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule
`default_nettype wire

FILE: rtl/core/cqe_datapath.sv
// slot memory, indices, capacity register and result register
`default_nettype none
module cqe_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cqe_pkg::cqe_in_t       cmd_in,
    input  wire cqe_pkg::cqe_cmd_t      cmd,
    input  wire logic                   cfg_we,
    input  wire logic [cqe_pkg::QS_W-1:0] cfg_data,
    output cqe_pkg::cqe_stat_t          stat,
    output cqe_pkg::cqe_out_t           result,
    output logic                        result_valid
);
    import cqe_pkg::*;

    logic [31:0]      mem [DEPTH];
    logic [IDX_W-1:0] head_reg, tail_reg, idx_reg, cnt_reg;
    logic             empty_reg;
    logic [QS_W-1:0]  qs_reg;
    logic [1:0]       kind_reg;
    logic [31:0]      value_reg;
    logic [31:0]      rd_data_reg;
    cqe_out_t         out_reg;
    logic             out_valid_reg;
    logic [IDX_W-1:0] tail_adv, head_adv, idx_adv, rd_addr;

    assign tail_adv = cqe_advance(tail_reg, qs_reg);
    assign head_adv = cqe_advance(head_reg, qs_reg);
    assign idx_adv  = cqe_advance(idx_reg, qs_reg);
    assign rd_addr  = cmd.read_next ? idx_adv : head_reg;

    assign stat.kind      = cqe_kind_t'(kind_reg);
    assign stat.empty     = empty_reg;
    assign stat.full      = (tail_adv == head_reg);
    assign stat.walk_last = (idx_reg == tail_reg) || (cnt_reg == IDX_W'(DEPTH - 1));

    // slot memory
    always_ff @(posedge clk)
    begin
        if (cmd.write_first)
            mem[0] <= value_reg;
        else if (cmd.write_next)
            mem[tail_adv] <= value_reg;
        if (cmd.read_head || cmd.read_next)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= cmd_in.kind;
            value_reg <= cmd_in.value;
        end
        if (cmd.read_head)
        begin
            idx_reg <= head_reg;
            cnt_reg <= '0;
        end
        else if (cmd.read_next)
        begin
            idx_reg <= idx_adv;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            out_reg.status <= cmd.emit_status;
            out_reg.data <= (cmd.emit_status == ST_OK) ? rd_data_reg : '0;
            out_reg.last <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            empty_reg <= 1'b1;
            qs_reg <= QS_W'(DEPTH);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.emit;
            if (cfg_we)
                qs_reg <= cfg_data;
            if (cmd.write_first)
            begin
                head_reg <= '0;
                tail_reg <= '0;
                empty_reg <= 1'b0;
            end
            else if (cmd.write_next)
                tail_reg <= tail_adv;
            else if (cmd.pop)
            begin
                if (head_reg == tail_reg)
                begin
                    head_reg <= '0;
                    tail_reg <= '0;
                    empty_reg <= 1'b1;
                end
                else
                    head_reg <= head_adv;
            end
        end
    end

    assign result = out_reg;
    assign result_valid = out_valid_reg;

endmodule
`default_nettype wire

FILE: rtl/core/circular_queue_engine.sv
// top level of the circular queue engine
`default_nettype none
// command channel: cmd is taken at a clock edge with start high and busy low.
// kind selects enqueue, dequeue, display all or peek; value is stored on enqueue.
// results: result_valid marks each result for one cycle; the receiver cannot stall.
// a successful enqueue gives no result; a full or empty case gives one status
// result with data zero and last set.
// sequence: start loads the item in the idle state; in the exec state an enqueue
// writes its slot and returns to idle, and an empty or full case emits its status
// result. dequeue and peek read the head slot in exec and emit it in the emit state;
// a display streams one result per cycle from the emit state, n results for n held
// items (at most 64), the last one marked. the slot memory has a registered read
// (rd_data_reg), and every result then passes through the result register.
// busy: busy is high outside the idle state and falls in the cycle of the final
// result, so a new command is taken only after the last one has finished.
// configuration: cfg_data sets the capacity (clamped to 1..64), written when
// cfg_valid and cfg_ready are high; write it only while the block is idle.
// reset: the queue is empty, the head and tail indices are zero and the capacity is 64.
module circular_queue_engine (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire cqe_pkg::cqe_in_t        cmd,
    output cqe_pkg::cqe_out_t            result,
    output logic                         result_valid,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [cqe_pkg::QS_W-1:0] cfg_data
);
    import cqe_pkg::*;

    cqe_cmd_t  ctl_cmd;
    cqe_stat_t dp_stat;

    assign cfg_ready = ~busy;

    cqe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (dp_stat),
        .cmd   (ctl_cmd),
        .busy  (busy)
    );

    cqe_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_in       (cmd),
        .cmd          (ctl_cmd),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .stat         (dp_stat),
        .result       (result),
        .result_valid (result_valid)
    );

`ifndef SYNTHESIS
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without work in progress");

    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != ST_OK) |-> result.last && (result.data == '0))
        else $error("status result malformed");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !$past(busy) |-> !result_valid)
        else $error("result while idle");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_circular_queue_engine.sv
`timescale 1ns / 100ps
// self-checking testbench for the circular queue engine: directed table, then random phases
module tb_circular_queue_engine;
    import cqe_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int N_PHASES    = 7;
    localparam int PHASE_ITEMS = 28;
    localparam int DRAIN_WAIT  = 4;

    typedef struct packed {
        logic       is_cfg;
        logic [6:0] cfg;
        cqe_in_t    item;
        logic       fixed;
        cqe_out_t   reply;
    } tab_row_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    cqe_in_t    cmd;
    cqe_out_t   result;
    logic       result_valid;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;

    logic signed [31:0] q_slots [DEPTH];
    bit                 q_written [DEPTH];
    logic [IDX_W-1:0]   q_head;
    logic [IDX_W-1:0]   q_tail;
    bit                 q_empty;
    logic [QS_W-1:0]    q_size;

    cqe_out_t step_out [$];
    cqe_out_t queue_replies [$];
    tab_row_t tab [$];
    cqe_out_t owed;
    int       errors = 0;
    int       n_items = 0;
    int       n_results = 0;
    int       n_full = 0;
    int       n_empty = 0;
    int       n_cfg = 0;
    bit       quiet = 1'b0;

    circular_queue_engine DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result       (result),
        .result_valid (result_valid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int capacity_now();
        if (q_size == 0)
            return 1;
        if (q_size > DEPTH)
            return DEPTH;
        return q_size;
    endfunction

    function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] idx);
        int n;
        n = idx + 1;
        if (n >= capacity_now() || n >= DEPTH)
            return '0;
        return n[IDX_W-1:0];
    endfunction

    function automatic void put_reply(input cqe_status_t st, input logic signed [31:0] d,
                                      input logic l);
        cqe_out_t r;
        r.status = st;
        r.data   = d;
        r.last   = l;
        step_out.push_back(r);
    endfunction

    function automatic void run_queue_op(input cqe_in_t it);
        logic [IDX_W-1:0] idx;
        int               k;
        bit               fin;
        step_out.delete();
        if (it.kind == KIND_ENQ)
        begin
            if (q_empty)
            begin
                q_head       = '0;
                q_tail       = '0;
                q_slots[0]   = it.value;
                q_written[0] = 1'b1;
                q_empty      = 1'b0;
            end
            else if (slot_after(q_tail) == q_head)
                put_reply(ST_FULL, '0, 1'b1);
            else
            begin
                q_tail            = slot_after(q_tail);
                q_slots[q_tail]   = it.value;
                q_written[q_tail] = 1'b1;
            end
        end
        else if (q_empty)
            put_reply(ST_EMPTY, '0, 1'b1);
        else if (it.kind == KIND_DISP)
        begin
            idx = q_head;
            k   = 0;
            do
            begin
                fin = (idx == q_tail) || (k + 1 >= DEPTH);
                put_reply(ST_OK, q_slots[idx], fin);
                k++;
                idx = slot_after(idx);
            end
            while (!fin);
        end
        else
        begin
            put_reply(ST_OK, q_slots[q_head], 1'b1);
            if (it.kind == KIND_DEQ)
            begin
                if (q_head == q_tail)
                begin
                    q_head  = '0;
                    q_tail  = '0;
                    q_empty = 1'b1;
                end
                else
                    q_head = slot_after(q_head);
            end
        end
    endfunction

    // a read walk that would hit a slot never written since reset
    function automatic bit touches_unwritten(input logic [1:0] kind);
        logic [IDX_W-1:0] idx;
        int               k;
        if (q_empty || kind == KIND_ENQ)
            return 1'b0;
        if (kind != KIND_DISP)
            return !q_written[q_head];
        idx = q_head;
        for (k = 0; k < DEPTH; k++)
        begin
            if (!q_written[idx])
                return 1'b1;
            if (idx == q_tail)
                return 1'b0;
            idx = slot_after(idx);
        end
        return 1'b0;
    endfunction

    function automatic cqe_in_t pick_item(input int enq_pct);
        cqe_in_t it;
        int      r;
        r = $urandom_range(99);
        if (r < enq_pct)
            it.kind = KIND_ENQ;
        else if (r < enq_pct + (100 - enq_pct) / 2)
            it.kind = KIND_DEQ;
        else if ($urandom_range(2) == 0)
            it.kind = KIND_DISP;
        else
            it.kind = KIND_PEEK;
        case ($urandom_range(7))
            0: it.value = 32'h7fff_ffff;
            1: it.value = 32'h8000_0000;
            2: it.value = 32'h0000_0000;
            3: it.value = 32'hffff_ffff;
            default: it.value = $urandom;
        endcase
        if (touches_unwritten(it.kind))
            it.kind = KIND_ENQ;
        return it;
    endfunction

    function automatic void tab_cmd(input cqe_kind_t kind, input logic signed [31:0] value,
                                    input bit fixed, input cqe_status_t st,
                                    input logic signed [31:0] d);
        tab_row_t row;
        row              = '0;
        row.item.kind    = kind;
        row.item.value   = value;
        row.fixed        = fixed;
        row.reply.status = st;
        row.reply.data   = d;
        row.reply.last   = 1'b1;
        tab.push_back(row);
    endfunction

    function automatic void tab_cfg(input logic [6:0] v);
        tab_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.cfg    = v;
        tab.push_back(row);
    endfunction

    task automatic issue(input cqe_in_t it, input bit fixed, input cqe_out_t reply);
        start <= 1'b1;
        cmd   <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        run_queue_op(it);
        n_items++;
        if (fixed)
            queue_replies.push_back(reply);
        else
            foreach (step_out[i])
                queue_replies.push_back(step_out[i]);
        if (!quiet && $urandom_range(99) < 9)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 9);
        end
    endtask

    task automatic set_capacity(input logic [6:0] v);
        start <= 1'b0;
        while (queue_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        q_size = v;
        n_cfg++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            n_results++;
            if (result.status == ST_FULL)
                n_full++;
            if (result.status == ST_EMPTY)
                n_empty++;
            if (queue_replies.size() == 0)
            begin
                errors++;
                $display("%0t: result with no item owed: status %0d data %h last %0d",
                         $time, result.status, result.data, result.last);
            end
            else
            begin
                owed = queue_replies.pop_front();
                if (result.status !== owed.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, owed.status, result.status);
                end
                if (result.data !== owed.data)
                begin
                    errors++;
                    $display("%0t: data expected %h actual %h", $time, owed.data, result.data);
                end
                if (result.last !== owed.last)
                begin
                    errors++;
                    $display("%0t: last expected %0d actual %0d", $time, owed.last, result.last);
                end
            end
        end
    end

    initial
    begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                stall = 0;
            else
                stall++;
        end
        $display("tb_circular_queue_engine NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        cqe_out_t none;
        int       pct;
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        none      = '0;
        q_head    = '0;
        q_tail    = '0;
        q_empty   = 1'b1;
        q_size    = 7'd64;
        foreach (q_slots[i])
            q_slots[i] = '0;

        tab_cmd(KIND_DEQ,  0,            1, ST_EMPTY, 0);
        tab_cmd(KIND_PEEK, 0,            1, ST_EMPTY, 0);
        tab_cmd(KIND_DISP, 0,            1, ST_EMPTY, 0);
        tab_cmd(KIND_ENQ,  32'h7fffffff, 0, ST_OK,    0);
        tab_cmd(KIND_PEEK, 32'hffffffff, 1, ST_OK,    32'h7fffffff);
        tab_cmd(KIND_ENQ,  32'h80000000, 0, ST_OK,    0);
        tab_cmd(KIND_ENQ,  32'hffffffff, 0, ST_OK,    0);
        tab_cmd(KIND_ENQ,  32'h00000000, 0, ST_OK,    0);
        tab_cmd(KIND_DISP, 0,            0, ST_OK,    0);
        tab_cmd(KIND_DEQ,  0,            1, ST_OK,    32'h7fffffff);
        tab_cmd(KIND_DEQ,  0,            1, ST_OK,    32'h80000000);
        tab_cmd(KIND_DEQ,  0,            1, ST_OK,    32'hffffffff);
        tab_cmd(KIND_DEQ,  0,            1, ST_OK,    32'h00000000);
        tab_cmd(KIND_DEQ,  0,            1, ST_EMPTY, 0);
        tab_cmd(KIND_ENQ,  32'h55555555, 0, ST_OK,    0);
        tab_cmd(KIND_ENQ,  32'haaaaaaaa, 0, ST_OK,    0);
        tab_cfg(7'd2);
        tab_cmd(KIND_ENQ,  32'h00000001, 1, ST_FULL,  0);
        tab_cmd(KIND_DISP, 0,            0, ST_OK,    0);
        tab_cfg(7'd0);
        tab_cmd(KIND_DEQ,  0,            0, ST_OK,    0);
        tab_cmd(KIND_DISP, 0,            0, ST_OK,    0);
        tab_cfg(7'd127);
        tab_cmd(KIND_DISP, 0,            0, ST_OK,    0);
        tab_cmd(KIND_DEQ,  0,            0, ST_OK,    0);
        tab_cmd(KIND_DEQ,  0,            0, ST_OK,    0);
        tab_cmd(KIND_PEEK, 0,            1, ST_EMPTY, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (tab[i])
            if (tab[i].is_cfg)
                set_capacity(tab[i].cfg);
            else
                issue(tab[i].item, tab[i].fixed, tab[i].reply);

        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0: set_capacity(7'd64);
                1: set_capacity(7'd1);
                2: set_capacity(7'($urandom_range(10, 20)));
                3: set_capacity(7'd0);
                4: set_capacity(7'($urandom_range(2, 9)));
                5: set_capacity(7'd127);
                default: set_capacity(7'($urandom_range(3, 63)));
            endcase
            quiet = (p == 2);
            pct   = (p % 2 == 0) ? 65 : 45;
            repeat (PHASE_ITEMS) issue(pick_item(pct), 1'b0, none);
        end

        start <= 1'b0;
        while (queue_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d items and %0d results, %0d queue-full and %0d queue-empty",
                 n_items, n_results, n_full, n_empty);
        $display("capacity rewritten %0d times, from 0 and 1 up to 64 and beyond", n_cfg);
        if (errors == 0)
            $display("tb_circular_queue_engine OK");
        else
            $display("tb_circular_queue_engine NOT OK");
        $finish;
    end

endmodule
